>>> hdl/eph_pkg.sv
// Shared types and constants for the edge profile hash counter.
// Holds item payload structs, function and status codes, hash constants
// and the command/status structs between controller and datapath.
`timescale 1ns / 1ps

package eph_pkg;

  // Function codes of an input item.
  localparam logic [1:0] FUNC_ENTER = 2'd0;
  localparam logic [1:0] FUNC_BREAK = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Status codes of a result item.
  localparam logic [2:0] STAT_NEW   = 3'd0;
  localparam logic [2:0] STAT_INC   = 3'd1;
  localparam logic [2:0] STAT_DROP  = 3'd2;
  localparam logic [2:0] STAT_NONE  = 3'd3;
  localparam logic [2:0] STAT_CLEAR = 3'd4;

  // Register index of the recording control register.
  localparam int REG_RECORDING = 0;

  // Field widths.
  localparam int KEY_W  = 64;
  localparam int CNT_W  = 32;
  localparam int DIST_W = 13;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // splitmix64 finalizer constants.
  localparam logic [KEY_W-1:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [KEY_W-1:0] MIX_C1     = 64'hbf58476d1ce4e5b9;
  localparam logic [KEY_W-1:0] MIX_C2     = 64'h94d049bb133111eb;
  localparam int MIX_SH1 = 30;
  localparam int MIX_SH2 = 27;
  localparam int MIX_SH3 = 31;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] block_start;
    logic [31:0] block_exit;
  } eph_in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [CNT_W-1:0]  edge_hits;
    logic [DIST_W-1:0] distinct_edges;
    logic [CNT_W-1:0]  lost_edges;
  } eph_out_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic accept;
    logic probe_init;
    logic mem_rd;
    logic probe_eval;
    logic sweep_wr;
    logic result_load;
  } eph_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic edge_req;
    logic clear_req;
    logic mix_done;
    logic slot_empty;
    logic slot_match;
    logic probe_last;
    logic sweep_last;
    logic out_busy;
  } eph_sts_t;

endpackage

>>> hdl/eph_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing; field names follow the item definitions.
`timescale 1ns / 1ps

interface eph_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] block_start;
  logic [31:0] block_exit;

  modport source (output valid, func, block_start, block_exit, input ready);
  modport sink   (input valid, func, block_start, block_exit, output ready);
endinterface

interface eph_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] edge_hits;
  logic [12:0] distinct_edges;
  logic [31:0] lost_edges;

  modport source (output valid, status, edge_hits, distinct_edges, lost_edges,
                  input ready);
  modport sink   (input valid, status, edge_hits, distinct_edges, lost_edges,
                  output ready);
endinterface

>>> hdl/eph_mix.sv
// Iterative splitmix64 finalizer built around one 32x32 multiplier.
// Depends on eph_pkg for the hash constants.
`timescale 1ns / 1ps

module eph_mix (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start_i,
  input  logic [63:0] key_i,
  output logic        done_o,
  output logic [63:0] hash_o
);

  typedef enum logic [5:0] {
    MX_IDLE = 6'b000001,
    MX_XS   = 6'b000010,
    MX_M0   = 6'b000100,
    MX_M1   = 6'b001000,
    MX_M2   = 6'b010000,
    MX_M3   = 6'b100000
  } mix_state_t;

  mix_state_t  state_r, state_nxt;
  logic        round_r, round_nxt;
  logic        done_r, done_nxt;
  logic [63:0] v_r, v_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] prod_r, prod_nxt;

  logic [63:0] c_sel;
  logic [63:0] xs_val;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  assign c_sel  = round_r ? eph_pkg::MIX_C2 : eph_pkg::MIX_C1;
  assign xs_val = round_r ? (v_r ^ (v_r >> eph_pkg::MIX_SH2))
                          : (v_r ^ (v_r >> eph_pkg::MIX_SH1));

  // A 64-bit product modulo 2^64 needs lo*lo plus the low halves of the two
  // cross products, added into the upper word.
  assign mul_a = (state_r == MX_M2) ? x_r[63:32] : x_r[31:0];
  assign mul_b = (state_r == MX_M1) ? c_sel[63:32] : c_sel[31:0];
  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    done_nxt  = 1'b0;
    v_nxt     = v_r;
    x_nxt     = x_r;
    prod_nxt  = prod_r;
    unique case (state_r)
      MX_IDLE: begin
        if (start_i) begin
          v_nxt     = key_i + eph_pkg::MIX_GOLDEN;
          round_nxt = 1'b0;
          state_nxt = MX_XS;
        end
      end
      MX_XS: begin
        x_nxt     = xs_val;
        state_nxt = MX_M0;
      end
      MX_M0: begin
        prod_nxt  = mul_p;
        state_nxt = MX_M1;
      end
      MX_M1: begin
        v_nxt     = prod_r;
        prod_nxt  = mul_p;
        state_nxt = MX_M2;
      end
      MX_M2: begin
        v_nxt     = {v_r[63:32] + prod_r[31:0], v_r[31:0]};
        prod_nxt  = mul_p;
        state_nxt = MX_M3;
      end
      MX_M3: begin
        v_nxt = {v_r[63:32] + prod_r[31:0], v_r[31:0]};
        if (round_r) begin
          done_nxt  = 1'b1;
          state_nxt = MX_IDLE;
        end else begin
          round_nxt = 1'b1;
          state_nxt = MX_XS;
        end
      end
      default: state_nxt = MX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MX_IDLE;
      round_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    x_r    <= x_nxt;
    prod_r <= prod_nxt;
  end

  assign done_o = done_r;
  assign hash_o = v_r ^ (v_r >> eph_pkg::MIX_SH3);

endmodule

>>> hdl/eph_dp.sv
// Datapath: chain state, key/count table memory, probe pointer, totals,
// the recording register and the output register. Uses eph_pkg and eph_mix.
`timescale 1ns / 1ps

module eph_dp #(
  parameter int TABLE_BITS  = 12,
  parameter int PROBE_LIMIT = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  eph_pkg::eph_cmd_t cmd_i,
  output eph_pkg::eph_sts_t sts_o,
  input  eph_pkg::eph_in_t  in_data_i,
  input  logic              cfg_wr_i,
  input  logic              cfg_wdata_i,
  output logic              recording_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output eph_pkg::eph_out_t out_data_o
);

  localparam int SLOTS   = 1 << TABLE_BITS;
  localparam int OCC_W   = TABLE_BITS + 1;
  localparam int PRB_W   = $clog2(PROBE_LIMIT + 1);
  localparam int KEY_W   = eph_pkg::KEY_W;
  localparam int CNT_W   = eph_pkg::CNT_W;
  localparam int DIST_W  = eph_pkg::DIST_W;
  localparam int ENTRY_W = KEY_W + CNT_W;

  // Each entry holds {key, count}; a count of zero marks the slot empty.
  logic [ENTRY_W-1:0] mem [SLOTS];
  logic [ENTRY_W-1:0] rdata_r;
  logic               mem_we;
  logic [ENTRY_W-1:0] mem_wdata;

  logic                  recording_r, recording_nxt;
  logic                  prev_valid_r, prev_valid_nxt;
  logic [31:0]           prev_exit_r, prev_exit_nxt;
  logic [TABLE_BITS-1:0] slot_r, slot_nxt;
  logic [PRB_W-1:0]      probe_n_r, probe_n_nxt;
  logic [OCC_W-1:0]      occ_r, occ_nxt;
  logic [CNT_W-1:0]      dropped_r, dropped_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [2:0]            res_status_r, res_status_nxt;
  logic [CNT_W-1:0]      res_hits_r, res_hits_nxt;
  eph_pkg::eph_out_t     out_data_r, out_data_nxt;

  logic [KEY_W-1:0]        rd_key;
  logic [CNT_W-1:0]        rd_cnt;
  logic [CNT_W-1:0]        inc_cnt;
  logic [KEY_W-1:0]        edge_key;
  logic                    edge_req;
  logic                    mix_start;
  logic                    mix_done;
  logic [KEY_W-1:0]        mix_hash;
  logic [OCC_W+DIST_W-1:0] occ_ext;

  assign rd_key   = rdata_r[ENTRY_W-1:CNT_W];
  assign rd_cnt   = rdata_r[CNT_W-1:0];
  assign inc_cnt  = (rd_cnt == eph_pkg::CNT_MAX) ? rd_cnt : rd_cnt + CNT_W'(1);
  assign edge_key = {prev_exit_r, in_data_i.block_start};
  assign edge_req = (in_data_i.func == eph_pkg::FUNC_ENTER) && recording_r && prev_valid_r;
  assign mix_start = cmd_i.accept && edge_req;
  assign occ_ext  = {{DIST_W{1'b0}}, occ_r};

  eph_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mix_start),
    .key_i   (edge_key),
    .done_o  (mix_done),
    .hash_o  (mix_hash)
  );

  always_comb begin
    sts_o.edge_req   = edge_req;
    sts_o.clear_req  = in_data_i.func == eph_pkg::FUNC_CLEAR;
    sts_o.mix_done   = mix_done;
    sts_o.slot_empty = rd_cnt == '0;
    sts_o.slot_match = rd_key == key_r;
    sts_o.probe_last = probe_n_r == PRB_W'(PROBE_LIMIT - 1);
    sts_o.sweep_last = &slot_r;
    sts_o.out_busy   = out_valid_r && !out_ready_i;
  end

  assign mem_we = cmd_i.sweep_wr ||
                  (cmd_i.probe_eval && (sts_o.slot_empty || sts_o.slot_match));
  assign mem_wdata = cmd_i.sweep_wr ? '0
                   : {key_r, sts_o.slot_empty ? CNT_W'(1) : inc_cnt};

  always_comb begin
    recording_nxt  = recording_r;
    prev_valid_nxt = prev_valid_r;
    prev_exit_nxt  = prev_exit_r;
    slot_nxt       = slot_r;
    probe_n_nxt    = probe_n_r;
    occ_nxt        = occ_r;
    dropped_nxt    = dropped_r;
    out_valid_nxt  = out_valid_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_hits_nxt   = res_hits_r;
    out_data_nxt   = out_data_r;

    if (cmd_i.accept) begin
      res_status_nxt = eph_pkg::STAT_NONE;
      res_hits_nxt   = '0;
      priority if (in_data_i.func == eph_pkg::FUNC_ENTER) begin
        if (!recording_r) begin
          prev_valid_nxt = 1'b0;
        end else begin
          key_nxt        = edge_key;
          prev_exit_nxt  = in_data_i.block_exit;
          prev_valid_nxt = 1'b1;
        end
      end else if (in_data_i.func == eph_pkg::FUNC_BREAK) begin
        prev_valid_nxt = 1'b0;
      end else if (in_data_i.func == eph_pkg::FUNC_CLEAR) begin
        occ_nxt        = '0;
        dropped_nxt    = '0;
        prev_valid_nxt = 1'b0;
        slot_nxt       = '0;
        res_status_nxt = eph_pkg::STAT_CLEAR;
      end else begin
        res_status_nxt = eph_pkg::STAT_NONE;
      end
    end

    if (cmd_i.probe_init) begin
      slot_nxt    = mix_hash[TABLE_BITS-1:0];
      probe_n_nxt = '0;
    end

    if (cmd_i.probe_eval) begin
      priority if (sts_o.slot_empty) begin
        occ_nxt        = occ_r + OCC_W'(1);
        res_status_nxt = eph_pkg::STAT_NEW;
        res_hits_nxt   = CNT_W'(1);
      end else if (sts_o.slot_match) begin
        res_status_nxt = eph_pkg::STAT_INC;
        res_hits_nxt   = inc_cnt;
      end else if (sts_o.probe_last) begin
        dropped_nxt    = (dropped_r == eph_pkg::CNT_MAX) ? dropped_r
                                                         : dropped_r + CNT_W'(1);
        res_status_nxt = eph_pkg::STAT_DROP;
        res_hits_nxt   = '0;
      end else begin
        slot_nxt    = slot_r + TABLE_BITS'(1);
        probe_n_nxt = probe_n_r + PRB_W'(1);
      end
    end

    if (cmd_i.sweep_wr) begin
      slot_nxt = slot_r + TABLE_BITS'(1);
    end

    if (out_valid_r && out_ready_i) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd_i.result_load) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.status         = res_status_r;
      out_data_nxt.edge_hits      = res_hits_r;
      out_data_nxt.distinct_edges = occ_ext[DIST_W-1:0];
      out_data_nxt.lost_edges     = dropped_r;
    end

    // Any write to the recording register breaks the chain.
    if (cfg_wr_i) begin
      recording_nxt  = cfg_wdata_i;
      prev_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recording_r  <= 1'b0;
      prev_valid_r <= 1'b0;
      prev_exit_r  <= '0;
      slot_r       <= '0;
      probe_n_r    <= '0;
      occ_r        <= '0;
      dropped_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      recording_r  <= recording_nxt;
      prev_valid_r <= prev_valid_nxt;
      prev_exit_r  <= prev_exit_nxt;
      slot_r       <= slot_nxt;
      probe_n_r    <= probe_n_nxt;
      occ_r        <= occ_nxt;
      dropped_r    <= dropped_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_hits_r   <= res_hits_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot_r] <= mem_wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_r <= mem[slot_r];
    end
  end

  assign recording_o = recording_r;
  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_data_r;

endmodule

>>> hdl/eph_ctrl.sv
// Controller state machine: sequences item accept, hashing, table probes,
// clearing sweeps and result hand-off. Uses the eph_pkg command/status types.
`timescale 1ns / 1ps

module eph_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  eph_pkg::eph_sts_t sts_i,
  output eph_pkg::eph_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_MIX    = 7'b0000100,
    S_READ   = 7'b0001000,
    S_CHECK  = 7'b0010000,
    S_CLEAR  = 7'b0100000,
    S_RESULT = 7'b1000000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd_o.sweep_wr = 1'b1;
        if (sts_i.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          priority if (sts_i.edge_req) begin
            state_nxt = S_MIX;
          end else if (sts_i.clear_req) begin
            state_nxt = S_CLEAR;
          end else begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_MIX: begin
        if (sts_i.mix_done) begin
          cmd_o.probe_init = 1'b1;
          state_nxt        = S_READ;
        end
      end
      S_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_nxt    = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.probe_eval = 1'b1;
        if (sts_i.slot_empty || sts_i.slot_match || sts_i.probe_last) begin
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_CLEAR: begin
        cmd_o.sweep_wr = 1'b1;
        if (sts_i.sweep_last) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!sts_i.out_busy) begin
          cmd_o.result_load = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/edge_profile_hash_counter_top.sv
// Top level of the edge profile hash counter: channels, APB register port,
// controller and datapath. Uses eph_pkg, eph_if, eph_ctrl and eph_dp.
//
//   Channel  Direction  Handshake       Payload
//   in_chan  sink       valid/ready     func, block_start, block_exit
//   out_chan source     valid/ready     status, edge_hits, distinct_edges, lost_edges
//   cfg_*    slave      APB, pready=1   reg 0: recording (bit 0)
//
// A break, disabled enter or edge-less enter goes from accept straight to the
// result state; an edge is hashed and then probes the table: the mixer shares
// one 32x32 multiplier over 10 steps, and each probe is a read and a check of the
// single-port table. A clear item sweeps 2^TABLE_BITS table entries, one per
// cycle. After reset the same sweep of all 2^TABLE_BITS entries runs with
// in_chan.ready low. A result waits in the output register; the next item is
// accepted meanwhile but its result is loaded only once that register frees.
`timescale 1ns / 1ps

module edge_profile_hash_counter_top #(
  parameter int TABLE_BITS  = 12,
  parameter int PROBE_LIMIT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  eph_in_if.sink      in_chan,
  eph_out_if.source   out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  eph_pkg::eph_cmd_t cmd;
  eph_pkg::eph_sts_t sts;
  eph_pkg::eph_in_t  in_data;
  eph_pkg::eph_out_t out_data;
  logic              cfg_wr;
  logic              recording;
  logic              cfg_hit;

  assign in_data.func        = in_chan.func;
  assign in_data.block_start = in_chan.block_start;
  assign in_data.block_exit  = in_chan.block_exit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = cfg_paddr[2] == 1'(eph_pkg::REG_RECORDING);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? {31'b0, recording} : '0;

  eph_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_chan.valid),
    .in_ready_o (in_chan.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  eph_dp #(
    .TABLE_BITS  (TABLE_BITS),
    .PROBE_LIMIT (PROBE_LIMIT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data),
    .cfg_wr_i    (cfg_wr),
    .cfg_wdata_i (cfg_pwdata[0]),
    .recording_o (recording),
    .out_valid_o (out_chan.valid),
    .out_ready_i (out_chan.ready),
    .out_data_o  (out_data)
  );

  assign out_chan.status         = out_data.status;
  assign out_chan.edge_hits      = out_data.edge_hits;
  assign out_chan.distinct_edges = out_data.distinct_edges;
  assign out_chan.lost_edges     = out_data.lost_edges;

  // The controller never issues two datapath commands in one cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.probe_init, cmd.mem_rd, cmd.probe_eval,
              cmd.sweep_wr, cmd.result_load}))
    else $error("controller issued overlapping datapath commands");

  // No item is taken while the table is being swept.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sweep_wr |-> !in_chan.ready)
    else $error("input ready during table sweep");

  // A result is only loaded when the output register is free or draining.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result_load |-> (!out_chan.valid || out_chan.ready))
    else $error("result loaded over a pending result");

  // A clear item starts the sweep right away.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.func == eph_pkg::FUNC_CLEAR)
      |=> cmd.sweep_wr)
    else $error("clear item did not start the sweep");

endmodule

>>> test/edge_profile_hash_counter_top_tb.sv
// Self-checking testbench for the edge profile hash counter top level.
// Drives items and APB register writes, predicts each untyped result with a local
// copy of the counter table. Depends on eph_pkg, eph_if and the RTL top level.
`timescale 1ns / 1ps

module edge_profile_hash_counter_top_tb;

  localparam int TABLE_BITS   = 12;
  localparam int PROBE_LIMIT  = 64;
  localparam int SLOTS        = 1 << TABLE_BITS;
  localparam int COLLIDE_N    = PROBE_LIMIT + 8;
  localparam int POOL_N       = 24;
  localparam int STALL_LIMIT  = 40000;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES   = 300;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 500;

  localparam logic [1:0] FUNC_UNUSED   = 2'd3;
  localparam logic       ROW_ITEM      = 1'b0;
  localparam logic       ROW_CFG       = 1'b1;

  typedef struct packed {
    logic              kind;
    logic              cfg_val;
    eph_pkg::eph_in_t  it;
    logic              typed;
    eph_pkg::eph_out_t res;
  } dir_row_t;

  localparam int DIR_ROWS = 23;

  // kind, register value, func, block_start, block_exit,
  // typed flag, status, edge_hits, distinct_edges, lost_edges
  dir_row_t dir_rows [DIR_ROWS] = '{
    {ROW_ITEM, 1'b0, eph_pkg::FUNC_ENTER, 32'h0, 32'h0,
     1'b1, eph_pkg::STAT_NONE, 32'd0, 13'd0, 32'd0},
    {ROW_CFG, 1'b1, eph_pkg::FUNC_ENTER, 32'h0, 32'h0,
     1'b0, eph_pkg::STAT_NONE, 32'd0, 13'd0, 32'd0},
    {ROW_ITEM, 1'b0, eph_pkg::FUNC_ENTER, 32'h0, 32'hFFFFFFFF,
     1'b1, eph_pkg::STAT_NONE, 32'd0, 13'd0, 32'd0},
    {ROW_ITEM, 1'b0, eph_pkg::FUNC_ENTER, 32'hFFFFFFFF, 32'h0,
     1'b1, eph_pkg::STAT_NEW, 32'd1, 13'd1, 32'd0},
    {ROW_ITEM, 1'b0, eph_pkg::FUNC_ENTER, 32'h0, 32'hFFFFFFFF,
     1'b1, eph_pkg::STAT_NEW, 32'd1, 13'd2, 32'd0},
    {ROW_ITEM, 1'b0, eph_pkg::FUNC_ENTER, 32'hFFFFFFFF, 32'h0,
     1'b1, eph_pkg::STAT_INC, 32'd2, 13'd2, 32'd0},
    {ROW_ITEM, 1'b0, eph_pkg::FUNC_ENTER, 32'h0, 32'hFFFFFFFF,
     1'b1, eph_pkg::STAT_INC, 32'd2, 13'd2, 32'd0},
    {ROW_ITEM, 1'b0, eph_pkg::FUNC_BREAK, 32'hFFFFFFFF, 32'hFFFFFFFF,
     1'b1, eph_pkg::STAT_NONE, 32'd0, 13'd2, 32'd0},
    {ROW_ITEM, 1'b0, eph_pkg::FUNC_ENTER, 32'h12345678, 32'h9ABCDEF0,
     1'b1, eph_pkg::STAT_NONE, 32'd0, 13'd2, 32'd0},
    {ROW_ITEM, 1'b0, FUNC_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF,
     1'b1, eph_pkg::STAT_NONE, 32'd0, 13'd2, 32'd0},
    {ROW_ITEM, 1'b0, eph_pkg::FUNC_ENTER, 32'hA5A5A5A5, 32'h5A5A5A5A,
     1'b0, eph_pkg::STAT_NONE, 32'd0, 13'd0, 32'd0},
    {ROW_ITEM, 1'b0, eph_pkg::FUNC_ENTER, 32'h5A5A5A5A, 32'hA5A5A5A5,
     1'b0, eph_pkg::STAT_NONE, 32'd0, 13'd0, 32'd0},
    {ROW_ITEM, 1'b0, eph_pkg::FUNC_CLEAR, 32'h0, 32'h0,
     1'b1, eph_pkg::STAT_CLEAR, 32'd0, 13'd0, 32'd0},
    {ROW_ITEM, 1'b0, eph_pkg::FUNC_ENTER, 32'h1, 32'h2,
     1'b1, eph_pkg::STAT_NONE, 32'd0, 13'd0, 32'd0},
    {ROW_ITEM, 1'b0, eph_pkg::FUNC_ENTER, 32'h2, 32'h3,
     1'b1, eph_pkg::STAT_NEW, 32'd1, 13'd1, 32'd0},
    {ROW_CFG, 1'b0, eph_pkg::FUNC_ENTER, 32'h0, 32'h0,
     1'b0, eph_pkg::STAT_NONE, 32'd0, 13'd0, 32'd0},
    {ROW_ITEM, 1'b0, eph_pkg::FUNC_ENTER, 32'h3, 32'h4,
     1'b1, eph_pkg::STAT_NONE, 32'd0, 13'd1, 32'd0},
    {ROW_ITEM, 1'b0, eph_pkg::FUNC_CLEAR, 32'h0, 32'h0,
     1'b1, eph_pkg::STAT_CLEAR, 32'd0, 13'd0, 32'd0},
    {ROW_CFG, 1'b1, eph_pkg::FUNC_ENTER, 32'h0, 32'h0,
     1'b0, eph_pkg::STAT_NONE, 32'd0, 13'd0, 32'd0},
    {ROW_ITEM, 1'b0, eph_pkg::FUNC_ENTER, 32'h4, 32'h5,
     1'b1, eph_pkg::STAT_NONE, 32'd0, 13'd0, 32'd0},
    {ROW_CFG, 1'b1, eph_pkg::FUNC_ENTER, 32'h0, 32'h0,
     1'b0, eph_pkg::STAT_NONE, 32'd0, 13'd0, 32'd0},
    {ROW_ITEM, 1'b0, eph_pkg::FUNC_ENTER, 32'h5, 32'h6,
     1'b1, eph_pkg::STAT_NONE, 32'd0, 13'd0, 32'd0},
    {ROW_ITEM, 1'b0, eph_pkg::FUNC_ENTER, 32'h6, 32'h7,
     1'b0, eph_pkg::STAT_NONE, 32'd0, 13'd0, 32'd0}
  };

  logic clk = 1'b0;
  logic rst_n;

  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  eph_in_if  in_chan ();
  eph_out_if out_chan ();

  edge_profile_hash_counter_top #(
    .TABLE_BITS  (TABLE_BITS),
    .PROBE_LIMIT (PROBE_LIMIT)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the counter table and its totals.
  logic [63:0]                edge_keys   [SLOTS];
  logic [31:0]                edge_counts [SLOTS];
  logic [31:0]                last_exit;
  logic                       last_exit_ok;
  logic [eph_pkg::DIST_W-1:0] occupied_cnt;
  logic [31:0]                dropped_cnt;
  logic                       recording_en;

  eph_pkg::eph_out_t profile_results [$];

  int err_cnt;
  int results_seen;
  int send_idle_pct;
  int recv_stall_pct;

  // Keys sharing one home slot, used to overflow a probe chain.
  logic [31:0] collide_src;
  logic [31:0] collide_dst [COLLIDE_N];
  logic [31:0] addr_pool   [POOL_N];

  int send_pcts [4] = '{0, 60, 0, 15};
  int recv_pcts [4] = '{0, 0, 60, 15};

  function automatic logic [63:0] mix64_finalize(input logic [63:0] v);
    logic [63:0] x;
    x = v + eph_pkg::MIX_GOLDEN;
    x = (x ^ (x >> eph_pkg::MIX_SH1)) * eph_pkg::MIX_C1;
    x = (x ^ (x >> eph_pkg::MIX_SH2)) * eph_pkg::MIX_C2;
    return x ^ (x >> eph_pkg::MIX_SH3);
  endfunction

  function automatic eph_pkg::eph_out_t profile_step(input eph_pkg::eph_in_t it);
    eph_pkg::eph_out_t     r;
    logic [63:0]           key;
    logic [63:0]           h;
    logic [TABLE_BITS-1:0] slot;
    bit                    done;
    r.status    = eph_pkg::STAT_NONE;
    r.edge_hits = '0;
    case (it.func)
      eph_pkg::FUNC_ENTER: begin
        if (!recording_en) begin
          last_exit_ok = 1'b0;
        end else begin
          if (last_exit_ok) begin
            key  = {last_exit, it.block_start};
            h    = mix64_finalize(key);
            done = 1'b0;
            for (int n = 0; n < PROBE_LIMIT && !done; n++) begin
              slot = TABLE_BITS'(h[TABLE_BITS-1:0] + n);
              if (edge_counts[slot] == '0) begin
                edge_keys[slot]   = key;
                edge_counts[slot] = 32'd1;
                occupied_cnt      = occupied_cnt + 1'b1;
                r.status          = eph_pkg::STAT_NEW;
                r.edge_hits       = 32'd1;
                done              = 1'b1;
              end else if (edge_keys[slot] == key) begin
                if (edge_counts[slot] != eph_pkg::CNT_MAX)
                  edge_counts[slot] = edge_counts[slot] + 1;
                r.status    = eph_pkg::STAT_INC;
                r.edge_hits = edge_counts[slot];
                done        = 1'b1;
              end
            end
            if (!done) begin
              if (dropped_cnt != eph_pkg::CNT_MAX) dropped_cnt = dropped_cnt + 1;
              r.status = eph_pkg::STAT_DROP;
            end
          end
          last_exit    = it.block_exit;
          last_exit_ok = 1'b1;
        end
      end
      eph_pkg::FUNC_BREAK: last_exit_ok = 1'b0;
      eph_pkg::FUNC_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) edge_counts[i] = '0;
        occupied_cnt = '0;
        dropped_cnt  = '0;
        last_exit_ok = 1'b0;
        r.status     = eph_pkg::STAT_CLEAR;
      end
      default: ;
    endcase
    r.distinct_edges = occupied_cnt;
    r.lost_edges     = dropped_cnt;
    return r;
  endfunction

  function automatic eph_pkg::eph_in_t make_item(input logic [1:0] func,
                                                 input logic [31:0] start,
                                                 input logic [31:0] exitpc);
    eph_pkg::eph_in_t it;
    it.func        = func;
    it.block_start = start;
    it.block_exit  = exitpc;
    return it;
  endfunction

  function automatic logic [31:0] pick_addr();
    if ($urandom_range(99) < 75) return addr_pool[$urandom_range(POOL_N - 1)];
    return $urandom;
  endfunction

  task automatic send_item(input eph_pkg::eph_in_t it, input bit typed,
                           input eph_pkg::eph_out_t typed_res);
    eph_pkg::eph_out_t pred;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid       = 1'b1;
    in_chan.func        = it.func;
    in_chan.block_start = it.block_start;
    in_chan.block_exit  = it.block_exit;
    do @(posedge clk); while (!in_chan.ready);
    pred = profile_step(it);
    profile_results.insert(profile_results.size(), typed ? typed_res : pred);
  endtask

  task automatic drain_results(input int settle);
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (profile_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Register writes happen only with the block idle; a read-back follows.
  task automatic set_recording(input logic value);
    drain_results(SETTLE_CYCLES);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = 3'(4 * eph_pkg::REG_RECORDING);
    cfg_pwdata  = {31'd0, value};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    recording_en = value;
    last_exit_ok = 1'b0;
    @(negedge clk);
    cfg_pwrite  = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[0] !== value) begin
      $error("recording: expected %0d, actual %0d", value, cfg_prdata[0]);
      err_cnt++;
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic run_random(input int n_items);
    int                k;
    int unsigned       r;
    eph_pkg::eph_out_t no_res;
    no_res = '0;
    k      = 0;
    while (k < n_items) begin
      r = $urandom_range(999);
      if ((k == 0 && recording_en) || r < 3) begin
        // A chain of edges that all hash to one home slot overruns the probe limit.
        send_item(make_item(eph_pkg::FUNC_BREAK, $urandom, $urandom), 1'b0, no_res);
        send_item(make_item(eph_pkg::FUNC_ENTER, $urandom, collide_src), 1'b0, no_res);
        for (int j = 0; j < COLLIDE_N; j++)
          send_item(make_item(eph_pkg::FUNC_ENTER, collide_dst[j], collide_src), 1'b0,
                    no_res);
        k += COLLIDE_N + 2;
      end else begin
        if (r < 8)
          send_item(make_item(eph_pkg::FUNC_CLEAR, $urandom, $urandom), 1'b0, no_res);
        else if (r < 38)
          send_item(make_item(eph_pkg::FUNC_BREAK, $urandom, $urandom), 1'b0, no_res);
        else if (r < 58)
          send_item(make_item(FUNC_UNUSED, $urandom, $urandom), 1'b0, no_res);
        else
          send_item(make_item(eph_pkg::FUNC_ENTER, pick_addr(), pick_addr()), 1'b0,
                    no_res);
        k++;
      end
    end
  endtask

  // Result side: random stalls plus one long hold-off that backs the block up.
  initial begin
    int                hold_left;
    bit                hold_done;
    eph_pkg::eph_out_t exp_res;
    hold_left      = 0;
    hold_done      = 1'b0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_chan.ready = 1'b0;
        hold_left--;
      end else begin
        out_chan.ready = ($urandom_range(99) >= recv_stall_pct);
      end
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        results_seen++;
        if (profile_results.size() == 0) begin
          $error("result item with none pending: status %0d", out_chan.status);
          err_cnt++;
        end else begin
          exp_res = profile_results.pop_front();
          if (out_chan.status !== exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, out_chan.status);
            err_cnt++;
          end
          if (out_chan.edge_hits !== exp_res.edge_hits) begin
            $error("edge_hits: expected %0d, actual %0d", exp_res.edge_hits,
                   out_chan.edge_hits);
            err_cnt++;
          end
          if (out_chan.distinct_edges !== exp_res.distinct_edges) begin
            $error("distinct_edges: expected %0d, actual %0d", exp_res.distinct_edges,
                   out_chan.distinct_edges);
            err_cnt++;
          end
          if (out_chan.lost_edges !== exp_res.lost_edges) begin
            $error("lost_edges: expected %0d, actual %0d", exp_res.lost_edges,
                   out_chan.lost_edges);
            err_cnt++;
          end
        end
      end
    end
  end

  // Ends the run when no item moves on either channel for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [63:0]           h;
    logic [31:0]           cand;
    logic [TABLE_BITS-1:0] collide_home;
    int                    found;

    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.func        = eph_pkg::FUNC_ENTER;
    in_chan.block_start = '0;
    in_chan.block_exit  = '0;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = 3'(4 * eph_pkg::REG_RECORDING);
    cfg_pwdata          = '0;
    err_cnt             = 0;
    results_seen        = 0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;

    for (int i = 0; i < SLOTS; i++) begin
      edge_keys[i]   = '0;
      edge_counts[i] = '0;
    end
    last_exit    = '0;
    last_exit_ok = 1'b0;
    occupied_cnt = '0;
    dropped_cnt  = '0;
    recording_en = 1'b0;

    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < POOL_N; i++) addr_pool[i] = $urandom;

    collide_src  = $urandom;
    cand         = $urandom;
    h            = mix64_finalize({collide_src, cand});
    collide_home = h[TABLE_BITS-1:0];
    found        = 0;
    while (found < COLLIDE_N) begin
      cand = cand + 1;
      h    = mix64_finalize({collide_src, cand});
      if (h[TABLE_BITS-1:0] == collide_home) begin
        collide_dst[found] = cand;
        found++;
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        set_recording(dir_rows[i].cfg_val);
      else
        send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
    end

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      set_recording(1'b1);
      run_random(460);
      set_recording(1'b0);
      run_random(40);
    end

    drain_results(END_CYCLES);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/eph_pkg.sv
hdl/eph_if.sv
hdl/eph_mix.sv
hdl/eph_dp.sv
hdl/eph_ctrl.sv
hdl/edge_profile_hash_counter_top.sv
test/edge_profile_hash_counter_top_tb.sv
